// ----- sv/swfs_pkg.sv -----
// Package for the band-limited square wave synthesiser: sizes, register indexes,
// the quarter-wave sine table and the odd-harmonic reciprocal table.
// No dependencies; imported by square_wave_fourier_synth.
package swfs_pkg;

    // Sizes
    localparam int MAX_HARMONIC    = 127;
    localparam int SINE_TABLE_BITS = 10;
    localparam int PHASE_BITS      = 16;

    localparam int SINE_N    = 1 << SINE_TABLE_BITS;
    localparam int SADDR_W   = SINE_TABLE_BITS + 1;
    localparam int N_HARM    = (MAX_HARMONIC + 1) / 2;
    localparam int HIDX_W    = (N_HARM > 1) ? $clog2(N_HARM) : 1;
    localparam int HCNT_W    = $clog2(N_HARM + 1);
    localparam int SINE_W    = 15;
    localparam int RECIP_W   = 17;
    localparam int TERM_W    = 34;
    localparam int ACC_W     = 40;
    localparam int P1_W      = ACC_W + 16;

    // Turn word keep mask: only the top PHASE_BITS of the 32-bit turn word count
    localparam logic [31:0] PHASE_KEEP = 32'(~((64'd1 << (32 - PHASE_BITS)) - 64'd1));

    // Q30 constants
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [31:0] FOUR_OVER_PI_Q30 = 32'sd1367130551;
    localparam int SINE_FULL = 32767;

    // Rounding shifts
    localparam int RND1_SH = 23;
    localparam int RND2_SH = 30;

    // Configuration register indexes
    localparam logic [7:0] REG_AMPLITUDE      = 8'd0;
    localparam logic [7:0] REG_PHASE_OFFSET   = 8'd1;
    localparam logic [7:0] REG_FREQUENCY      = 8'd2;
    localparam logic [7:0] REG_HARMONIC_BOUND = 8'd3;

    // Reset values
    localparam logic signed [15:0] AMPLITUDE_RST = 16'sd256;
    localparam logic [15:0] PHASE_OFFSET_RST     = 16'd0;
    localparam logic [15:0] FREQUENCY_RST        = 16'd655;
    localparam logic [7:0]  HARMONIC_BOUND_RST   = 8'd3;

    typedef logic [SINE_W-1:0]  t_sine_tab  [0:SINE_N];
    typedef logic [RECIP_W-1:0] t_recip_tab [0:N_HARM-1];

    // Truncating unsigned quotient by shift and subtract, for table building
    function automatic longint unsigned f_udiv(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            q   = {q[62:0], 1'b0};
            if (rem >= den) begin
                rem  = rem - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // Quarter-wave sine, Q15, from a truncating Q30 Taylor series to x^15
    function automatic t_sine_tab f_build_sine();
        t_sine_tab       tab;
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        longint          r;
        for (int j = 0; j <= SINE_N; j++) begin
            x    = (HALF_PI_Q30 * longint'(j)) >> SINE_TABLE_BITS;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 7; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = f_udiv(term, 64'((2 * n) * (2 * n + 1)));
                if ((n & 1) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            r = longint'((unsigned'(sum) * SINE_FULL + (64'd1 << 29)) >> 30);
            if (r > SINE_FULL) begin
                r = SINE_FULL;
            end
            tab[j] = SINE_W'(r);
        end
        return tab;
    endfunction

    // Q16 reciprocal of odd harmonic 2h+1, rounded
    function automatic t_recip_tab f_build_recip();
        t_recip_tab tab;
        int         k;
        for (int h = 0; h < N_HARM; h++) begin
            k      = 2 * h + 1;
            tab[h] = RECIP_W'(f_udiv(64'(65536 + h), 64'(k)));
        end
        return tab;
    endfunction

    localparam t_sine_tab  SINE_TAB  = f_build_sine();
    localparam t_recip_tab RECIP_TAB = f_build_recip();

endpackage

// ----- sv/square_wave_fourier_synth.sv -----
// Band-limited square wave synthesiser: one Q15.16 sample per sample index.
// Depends on swfs_pkg (sizes, register indexes, sine and reciprocal tables).
// The loop runs n = min(bound/2, 64) harmonics. A new sample is taken only in the
// idle state, after the previous one has passed the per-harmonic multiply-accumulate
// loop, the scaling states and the output register; a stalled output holds the
// sequencer in its done state and so holds off the next sample.
// Reset (synchronous, active low) clears control and restores register defaults.
module square_wave_fourier_synth (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample_index
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] sample_value
);
    import swfs_pkg::*;

    // Sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SETUP = 4'd1;  // step = F * t
    localparam logic [3:0] ST_INIT  = 4'd2;  // first harmonic phase
    localparam logic [3:0] ST_RUN   = 4'd3;  // issue one harmonic per cycle
    localparam logic [3:0] ST_DRAIN = 4'd4;  // let the MAC pipeline empty
    localparam logic [3:0] ST_MUL1  = 4'd5;  // acc * amplitude
    localparam logic [3:0] ST_ABS1  = 4'd6;
    localparam logic [3:0] ST_RND1  = 4'd7;
    localparam logic [3:0] ST_MUL2  = 4'd8;  // v * 4/pi
    localparam logic [3:0] ST_ABS2  = 4'd9;
    localparam logic [3:0] ST_RND2  = 4'd10; // round and saturate
    localparam logic [3:0] ST_DONE  = 4'd11; // wait for the output register

    // Configuration registers
    logic signed [15:0] r_amplitude;
    logic [15:0]        r_phase_offset;
    logic [15:0]        r_frequency;
    logic [7:0]         r_harmonic_bound;

    // Sequencer and datapath
    logic [3:0]           r_state;
    logic [15:0]          r_t;
    logic [15:0]          r_step;
    logic [15:0]          r_phase;
    logic [HCNT_W-1:0]    r_hcnt;
    logic                 r_v1;
    logic                 r_v2;
    logic [SINE_W-1:0]    r_sine_mag;
    logic                 r_sine_neg;
    logic [RECIP_W-1:0]   r_recip;
    logic signed [TERM_W-1:0] r_term;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [63:0]   r_prod;
    logic [63:0]          r_mag;
    logic                 r_sign;
    logic signed [31:0]   r_v;
    logic [31:0]          r_result;
    logic                 r_out_valid;
    logic [31:0]          r_out_data;

    // Configuration must only be written while idle; the block does not enforce that, so it is always ready
    assign o_cfg_ready = 1'b1;

    // The output register parts the two sides: take a new item whenever idle
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Number of odd harmonics below the bound, capped at the table size
    logic [6:0]        w_half_bound;
    logic [HCNT_W-1:0] w_nharm;
    assign w_half_bound = r_harmonic_bound[7:1];
    assign w_nharm = (32'(w_half_bound) > N_HARM) ? HCNT_W'(N_HARM) : HCNT_W'(w_half_bound);

    // Step phase: k*F*t mod one turn advances by 2*F*t per odd harmonic
    logic [31:0] w_ft;
    assign w_ft = r_frequency * r_t;

    // Quadrant and table address from the current harmonic phase
    logic [31:0]                w_word;
    logic [1:0]                 w_quad;
    logic [SINE_TABLE_BITS-1:0] w_idx;
    logic [SADDR_W-1:0]         w_saddr;
    assign w_word  = {r_phase, 16'd0} & PHASE_KEEP;
    assign w_quad  = w_word[31:30];
    assign w_idx   = w_word[29 -: SINE_TABLE_BITS];
    assign w_saddr = w_quad[0] ? (SADDR_W'(SINE_N) - SADDR_W'(w_idx)) : SADDR_W'(w_idx);

    // Signed sine times unsigned Q16 reciprocal
    logic signed [SINE_W:0]   w_sine;
    logic signed [TERM_W-1:0] w_term;
    assign w_sine = r_sine_neg ? -$signed({1'b0, r_sine_mag}) : $signed({1'b0, r_sine_mag});
    assign w_term = w_sine * $signed({1'b0, r_recip});

    // Scaling multiplies
    logic signed [P1_W-1:0] w_p1;
    logic signed [63:0]     w_p2;
    assign w_p1 = r_acc * r_amplitude;
    assign w_p2 = r_v * FOUR_OVER_PI_Q30;

    // Round half away from zero on the magnitude
    logic [63:0] w_rnd1;
    logic [63:0] w_rnd2;
    assign w_rnd1 = (r_mag + (64'd1 << (RND1_SH - 1))) >> RND1_SH;
    assign w_rnd2 = (r_mag + (64'd1 << (RND2_SH - 1))) >> RND2_SH;

    // Saturate to signed 32 bits
    logic [31:0] w_sat;
    always_comb begin
        if (!r_sign && (w_rnd2 > 64'h7FFF_FFFF)) begin
            w_sat = 32'h7FFF_FFFF;
        end else if (r_sign && (w_rnd2 > 64'h8000_0000)) begin
            w_sat = 32'h8000_0000;
        end else if (r_sign) begin
            w_sat = 32'(-w_rnd2);
        end else begin
            w_sat = w_rnd2[31:0];
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude      <= AMPLITUDE_RST;
            r_phase_offset   <= PHASE_OFFSET_RST;
            r_frequency      <= FREQUENCY_RST;
            r_harmonic_bound <= HARMONIC_BOUND_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_AMPLITUDE:      r_amplitude      <= $signed(i_cfg_data);
                REG_PHASE_OFFSET:   r_phase_offset   <= i_cfg_data;
                REG_FREQUENCY:      r_frequency      <= i_cfg_data;
                REG_HARMONIC_BOUND: r_harmonic_bound <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Sequencer and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hcnt      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // MAC pipeline valids advance every cycle
            r_v1 <= (r_state == ST_RUN) && (r_hcnt != w_nharm);
            r_v2 <= r_v1;

            // Load the output when free, drop it once it has been transferred
            if ((r_state == ST_DONE) && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= ST_SETUP;
                    end
                end
                ST_SETUP: r_state <= ST_INIT;
                ST_INIT: begin
                    r_hcnt  <= '0;
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    if (r_hcnt == w_nharm) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_hcnt <= r_hcnt + HCNT_W'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!r_v1 && !r_v2) begin
                        r_state <= ST_MUL1;
                    end
                end
                ST_MUL1: r_state <= ST_ABS1;
                ST_ABS1: r_state <= ST_RND1;
                ST_RND1: r_state <= ST_MUL2;
                ST_MUL2: r_state <= ST_ABS2;
                ST_ABS2: r_state <= ST_RND2;
                ST_RND2: r_state <= ST_DONE;
                ST_DONE: begin
                    // Hold the result until the output register is free
                    if (!r_out_valid || m_axis_tready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    r_t <= s_axis_tdata;
                end
            end
            ST_SETUP: r_step <= w_ft[15:0];
            ST_INIT: begin
                r_phase <= r_step + r_phase_offset;
                r_acc   <= '0;
            end
            ST_RUN: begin
                // Issue: registered table reads for the current harmonic
                if (r_hcnt != w_nharm) begin
                    r_sine_mag <= SINE_TAB[w_saddr];
                    r_sine_neg <= w_quad[1];
                    r_recip    <= RECIP_TAB[r_hcnt[HIDX_W-1:0]];
                    r_phase    <= r_phase + {r_step[14:0], 1'b0};
                end
            end
            ST_MUL1: r_prod <= 64'(w_p1);
            ST_ABS1, ST_ABS2: begin
                r_sign <= r_prod[63];
                r_mag  <= r_prod[63] ? 64'(-r_prod) : 64'(r_prod);
            end
            // The first rounded value stays far inside 32 bits for any input
            ST_RND1: r_v <= r_sign ? -$signed(w_rnd1[31:0]) : $signed(w_rnd1[31:0]);
            ST_MUL2: r_prod <= w_p2;
            ST_RND2: r_result <= w_sat;
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    r_out_data <= r_result;
                end
            end
            default: ;
        endcase

        // Multiply and accumulate stages run behind the issue stage
        if (r_v1) begin
            r_term <= w_term;
        end
        if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_term);
        end
    end

endmodule
